FILE: hw/rtl/itlet_pkg.sv
// itlet_pkg: shared types and constants of the id tagged lru entry table
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package itlet_pkg;

  // table geometry
  localparam int unsigned Entries = 12;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned RankW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned IdW     = 32;
  localparam int unsigned TypeW   = 3;

  // rank held by the oldest entry of a full table
  localparam logic [RankW-1:0] OldestRank = RankW'(Entries - 1);
  // first id issued after reset
  localparam logic [IdW-1:0]   IdReset    = IdW'(1);

  // request codes; 5 to 7 are no-ops
  typedef enum logic [TypeW-1:0] {
    ReqCreate  = 3'd0,
    ReqEndData = 3'd1,
    ReqCancel  = 3'd2,
    ReqFetch   = 3'd3,
    ReqQuery   = 3'd4
  } req_type_e;

  // input word
  typedef struct packed {
    logic [TypeW-1:0] req_type;
    logic [IdW-1:0]   entry_id;
  } req_t;

  // result word
  typedef struct packed {
    logic [IdW-1:0] assigned_id;
    logic           present;
    logic           complete;
    logic           accepted;
    logic           evicted;
    logic [IdW-1:0] evicted_id;
  } rsp_t;

  // lookup status from the tag compare to the update logic
  typedef struct packed {
    logic             hit;
    logic [IdxW-1:0]  hit_idx;
    logic [RankW-1:0] hit_rank;
    logic             hit_complete;
    logic             full;
    logic [IdxW-1:0]  free_idx;
    logic [IdxW-1:0]  oldest_idx;
    logic [IdW-1:0]   oldest_tag;
  } lookup_t;

endpackage

FILE: hw/rtl/itlet_lookup.sv
// itlet_lookup: parallel tag compare, free slot search and oldest slot pick
// depends on itlet_pkg
`timescale 1ns / 1ps

module itlet_lookup (
  input  logic [itlet_pkg::Entries-1:0]                       valid_i,
  input  logic [itlet_pkg::Entries-1:0]                       complete_i,
  input  logic [itlet_pkg::Entries-1:0][itlet_pkg::IdW-1:0]   tag_i,
  input  logic [itlet_pkg::Entries-1:0][itlet_pkg::RankW-1:0] rank_i,
  input  logic [itlet_pkg::IdW-1:0]                           key_i,
  output itlet_pkg::lookup_t                                  look_o
);

  logic [itlet_pkg::Entries-1:0] match;

  // one comparator per slot
  always_comb begin
    for (int i = 0; i < itlet_pkg::Entries; i++) begin
      match[i] = valid_i[i] && (tag_i[i] == key_i);
    end
  end

  // lowest matching slot, lowest free slot, slot holding the oldest rank
  always_comb begin
    look_o            = '0;
    look_o.hit        = |match;
    look_o.full       = &valid_i;
    for (int i = itlet_pkg::Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        look_o.hit_idx = itlet_pkg::IdxW'(i);
      end
      if (!valid_i[i]) begin
        look_o.free_idx = itlet_pkg::IdxW'(i);
      end
      if (valid_i[i] && (rank_i[i] == itlet_pkg::OldestRank)) begin
        look_o.oldest_idx = itlet_pkg::IdxW'(i);
      end
    end
    look_o.hit_rank     = rank_i[look_o.hit_idx];
    look_o.hit_complete = complete_i[look_o.hit_idx];
    look_o.oldest_tag   = tag_i[look_o.oldest_idx];
  end

endmodule

FILE: hw/rtl/itlet_table.sv
// itlet_table: slot storage, id counter and the per-request table update
// depends on itlet_pkg and itlet_lookup
`timescale 1ns / 1ps

module itlet_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  itlet_pkg::req_t   req_i,
  output itlet_pkg::rsp_t   rsp_o
);

  logic [itlet_pkg::Entries-1:0]                       slot_valid_q, slot_valid_d;
  logic [itlet_pkg::Entries-1:0]                       slot_complete_q, slot_complete_d;
  logic [itlet_pkg::Entries-1:0][itlet_pkg::IdW-1:0]   slot_tag_q, slot_tag_d;
  logic [itlet_pkg::Entries-1:0][itlet_pkg::RankW-1:0] slot_rank_q, slot_rank_d;
  logic [itlet_pkg::IdW-1:0]                           next_id_q, next_id_d;

  logic                        is_create, is_end, is_cancel, is_fetch, is_query;
  logic [itlet_pkg::IdW-1:0]   key;
  itlet_pkg::lookup_t          look;

  // actions for this request
  logic                        do_touch, do_remove, do_grow, do_install, do_set_done;
  logic [itlet_pkg::IdxW-1:0]  tgt_idx;
  logic [itlet_pkg::RankW-1:0] tgt_rank;

  // request decode; a create looks up the id it is about to issue
  assign is_create = req_i.req_type == itlet_pkg::ReqCreate;
  assign is_end    = req_i.req_type == itlet_pkg::ReqEndData;
  assign is_cancel = req_i.req_type == itlet_pkg::ReqCancel;
  assign is_fetch  = req_i.req_type == itlet_pkg::ReqFetch;
  assign is_query  = req_i.req_type == itlet_pkg::ReqQuery;
  assign key       = is_create ? next_id_q : req_i.entry_id;

  itlet_lookup u_lookup (
    .valid_i    (slot_valid_q),
    .complete_i (slot_complete_q),
    .tag_i      (slot_tag_q),
    .rank_i     (slot_rank_q),
    .key_i      (key),
    .look_o     (look)
  );

  // pick the slot to act on and what happens to it
  always_comb begin
    do_touch    = 1'b0;
    do_remove   = 1'b0;
    do_grow     = 1'b0;
    do_install  = 1'b0;
    do_set_done = 1'b0;
    tgt_idx     = look.hit_idx;
    tgt_rank    = look.hit_rank;
    if (is_create) begin
      if (look.hit) begin
        // reuse the held entry
        do_touch = 1'b1;
      end else if (look.full) begin
        // evict the oldest and reuse its slot as most recent
        do_touch   = 1'b1;
        do_install = 1'b1;
        tgt_idx    = look.oldest_idx;
        tgt_rank   = itlet_pkg::OldestRank;
      end else begin
        do_grow    = 1'b1;
        do_install = 1'b1;
        tgt_idx    = look.free_idx;
      end
    end else if (look.hit) begin
      do_set_done = is_end && !look.hit_complete;
      do_remove   = is_cancel;
      do_touch    = is_fetch && look.hit_complete;
    end
  end

  // next state of every slot
  always_comb begin
    slot_valid_d    = slot_valid_q;
    slot_complete_d = slot_complete_q;
    slot_tag_d      = slot_tag_q;
    slot_rank_d     = slot_rank_q;
    next_id_d       = next_id_q;
    if (fire_i) begin
      if (is_create) begin
        next_id_d = next_id_q + itlet_pkg::IdW'(1);
      end
      for (int i = 0; i < itlet_pkg::Entries; i++) begin
        if (itlet_pkg::IdxW'(i) == tgt_idx) begin
          if (is_create) begin
            slot_complete_d[i] = 1'b0;
            slot_rank_d[i]     = '0;
          end
          if (do_install) begin
            slot_valid_d[i] = 1'b1;
            slot_tag_d[i]   = next_id_q;
          end
          if (do_set_done) begin
            slot_complete_d[i] = 1'b1;
          end
          if (do_remove) begin
            slot_valid_d[i]    = 1'b0;
            slot_complete_d[i] = 1'b0;
          end
          if (do_touch) begin
            slot_rank_d[i] = '0;
          end
        end else if (slot_valid_q[i]) begin
          if ((do_touch && (slot_rank_q[i] < tgt_rank)) || do_grow) begin
            slot_rank_d[i] = slot_rank_q[i] + itlet_pkg::RankW'(1);
          end else if (do_remove && (slot_rank_q[i] > tgt_rank)) begin
            slot_rank_d[i] = slot_rank_q[i] - itlet_pkg::RankW'(1);
          end
        end
      end
    end
  end

  // result word
  always_comb begin
    rsp_o             = '0;
    rsp_o.assigned_id = is_create ? next_id_q : '0;
    rsp_o.present     = (is_end || is_cancel || is_fetch || is_query) && look.hit;
    rsp_o.complete    = rsp_o.present && look.hit_complete;
    rsp_o.accepted    = is_create || do_set_done || do_remove || (do_touch && is_fetch);
    rsp_o.evicted     = is_create && !look.hit && look.full;
    rsp_o.evicted_id  = rsp_o.evicted ? look.oldest_tag : '0;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q    <= '0;
      slot_complete_q <= '0;
      next_id_q       <= itlet_pkg::IdReset;
    end else begin
      slot_valid_q    <= slot_valid_d;
      slot_complete_q <= slot_complete_d;
      next_id_q       <= next_id_d;
    end
  end

  // tags and ranks, meaningful only while the slot is valid
  always_ff @(posedge clk_i) begin
    slot_tag_q  <= slot_tag_d;
    slot_rank_q <= slot_rank_d;
  end

endmodule

FILE: hw/rtl/id_tagged_lru_entry_table_core.sv
// id_tagged_lru_entry_table_core: top level, input register, table, result register
// depends on itlet_pkg and itlet_table
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_ready_o | itlet_pkg::req_t
//   out     | output    | out_valid_o/out_ready_i | itlet_pkg::rsp_t
//
// a word is taken into the input register, resolved against the table and
// written to the result register; one word per cycle while the result side is
// not stalled, set by the single compare-and-update pass.
// the table changes at the same edge at which the result is registered, so
// every word sees the effect of the one before it.
// a stalled result register holds the input register; the input side keeps
// taking words while either register has room. reset empties both registers,
// clears every slot and sets the id counter to one.
`timescale 1ns / 1ps

module id_tagged_lru_entry_table_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  itlet_pkg::req_t in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output itlet_pkg::rsp_t out_word_o
);

  logic            in_valid_q;
  itlet_pkg::req_t in_word_q;
  logic            out_valid_q;
  itlet_pkg::rsp_t out_word_q, out_word_d;
  logic            advance, fire;

  // pipeline flow
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  itlet_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_word_q),
    .rsp_o  (out_word_d)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // word registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: hw/rtl/itlet_checker.sv
// itlet_checker: port level checks on the table core, attached by bind
// depends on itlet_pkg and id_tagged_lru_entry_table_core
`timescale 1ns / 1ps

module itlet_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input itlet_pkg::req_t in_word_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input itlet_pkg::rsp_t out_word_o
);

  // a stalled result stays with its word unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // an empty result register never holds off the input
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // an eviction comes only from a create, which always changes the table
  a_evict_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.evicted |-> out_word_o.accepted && !out_word_o.present)
    else $error("eviction reported outside a create");

  // evicted id is zero unless an eviction is reported
  a_evict_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.evicted |-> out_word_o.evicted_id == '0)
    else $error("evicted id without eviction");

  // a complete mark is only reported for a present entry
  a_complete_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.complete |-> out_word_o.present)
    else $error("complete reported for an absent entry");

endmodule

bind id_tagged_lru_entry_table_core itlet_checker u_itlet_checker (.*);

FILE: tb/id_tagged_lru_entry_table_core_tb.sv
// id_tagged_lru_entry_table_core_tb: self-checking bench for the lru entry table core
// depends on itlet_pkg and id_tagged_lru_entry_table_core; predicts every result word
`timescale 1ns / 1ps

module id_tagged_lru_entry_table_core_tb;

  localparam int StallLimit = 1000;
  localparam int TailCycles = 8;
  localparam int IdlePct    = 23;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic            in_valid  = 1'b0;
  logic            out_ready = 1'b0;
  itlet_pkg::req_t in_word   = '0;
  logic            in_ready_o;
  logic            out_valid_o;
  itlet_pkg::rsp_t out_word_o;

  // words waiting to be driven and results waiting to arrive
  itlet_pkg::req_t queued_requests[$];
  itlet_pkg::rsp_t predicted_results[$];

  bit no_idle     = 1'b0;
  int mismatches  = 0;
  int idle_cycles = 0;

  // shadow copy of the table
  logic                          tbl_valid    [itlet_pkg::Entries];
  logic                          tbl_complete [itlet_pkg::Entries];
  logic [itlet_pkg::IdW-1:0]     tbl_id       [itlet_pkg::Entries];
  logic [itlet_pkg::RankW-1:0]   tbl_rank     [itlet_pkg::Entries];
  logic [itlet_pkg::IdW-1:0]     id_counter;

  id_tagged_lru_entry_table_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_word_o (out_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // make slot s most recent; the more recent ones age by one
  function automatic void promote_slot(int s);
    logic [itlet_pkg::RankW-1:0] r;
    r = tbl_rank[s];
    for (int i = 0; i < itlet_pkg::Entries; i++) begin
      if (tbl_valid[i] && i != s && tbl_rank[i] < r)
        tbl_rank[i] = tbl_rank[i] + itlet_pkg::RankW'(1);
    end
    tbl_rank[s] = '0;
  endfunction

  // drop slot s; the older ones move up by one
  function automatic void drop_slot(int s);
    logic [itlet_pkg::RankW-1:0] r;
    r = tbl_rank[s];
    tbl_valid[s]    = 1'b0;
    tbl_complete[s] = 1'b0;
    for (int i = 0; i < itlet_pkg::Entries; i++) begin
      if (tbl_valid[i] && tbl_rank[i] > r)
        tbl_rank[i] = tbl_rank[i] - itlet_pkg::RankW'(1);
    end
  endfunction

  // apply one request word to the shadow table and return its result word
  function automatic itlet_pkg::rsp_t table_apply(itlet_pkg::req_t w);
    itlet_pkg::rsp_t r;
    logic [itlet_pkg::IdW-1:0] key;
    int hit;
    int free_slot;
    int oldest;
    r = '0;
    hit = -1;
    free_slot = -1;
    oldest = -1;
    key = (w.req_type == itlet_pkg::ReqCreate) ? id_counter : w.entry_id;
    for (int i = 0; i < itlet_pkg::Entries; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_id[i] == key) hit = i;
    end
    case (w.req_type)
      itlet_pkg::ReqCreate: begin
        r.assigned_id = id_counter;
        r.accepted    = 1'b1;
        id_counter    = id_counter + itlet_pkg::IdW'(1);
        if (hit >= 0) begin
          // only reachable once the id counter has wrapped
          tbl_complete[hit] = 1'b0;
          promote_slot(hit);
        end else begin
          for (int i = 0; i < itlet_pkg::Entries; i++) begin
            if (!tbl_valid[i]) begin
              if (free_slot < 0) free_slot = i;
            end else if (oldest < 0 || tbl_rank[i] > tbl_rank[oldest]) begin
              oldest = i;
            end
          end
          // full table: push out the oldest entry
          if (free_slot < 0) begin
            r.evicted    = 1'b1;
            r.evicted_id = tbl_id[oldest];
            drop_slot(oldest);
            free_slot = oldest;
          end
          for (int i = 0; i < itlet_pkg::Entries; i++) begin
            if (tbl_valid[i]) tbl_rank[i] = tbl_rank[i] + itlet_pkg::RankW'(1);
          end
          tbl_valid[free_slot]    = 1'b1;
          tbl_complete[free_slot] = 1'b0;
          tbl_id[free_slot]       = key;
          tbl_rank[free_slot]     = '0;
        end
      end
      itlet_pkg::ReqEndData, itlet_pkg::ReqCancel, itlet_pkg::ReqFetch,
      itlet_pkg::ReqQuery: begin
        if (hit >= 0) begin
          r.present  = 1'b1;
          r.complete = tbl_complete[hit];
          if (w.req_type == itlet_pkg::ReqEndData && !tbl_complete[hit]) begin
            tbl_complete[hit] = 1'b1;
            r.accepted = 1'b1;
          end else if (w.req_type == itlet_pkg::ReqCancel) begin
            drop_slot(hit);
            r.accepted = 1'b1;
          end else if (w.req_type == itlet_pkg::ReqFetch && tbl_complete[hit]) begin
            promote_slot(hit);
            r.accepted = 1'b1;
          end
        end
      end
      default: begin
        // unused codes leave everything at zero
      end
    endcase
    return r;
  endfunction

  task automatic report_field(string name, logic [itlet_pkg::IdW-1:0] want,
                              logic [itlet_pkg::IdW-1:0] got);
    $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
    mismatches++;
  endtask

  // driver: presents queued words, predicts each one as it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) predicted_results.push_back(table_apply(in_word));
      if (!in_valid || in_ready_o) begin
        if (queued_requests.size() > 0 && (no_idle || $urandom_range(0, 99) >= IdlePct)) begin
          in_word  <= queued_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back pressure and field compare against the oldest prediction
  always @(posedge clk_i) begin
    itlet_pkg::rsp_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t ns: result word with none expected, got %h", $time, out_word_o);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_word_o.assigned_id !== want.assigned_id)
            report_field("assigned_id", want.assigned_id, out_word_o.assigned_id);
          if (out_word_o.present !== want.present)
            report_field("present", itlet_pkg::IdW'(want.present),
                         itlet_pkg::IdW'(out_word_o.present));
          if (out_word_o.complete !== want.complete)
            report_field("complete", itlet_pkg::IdW'(want.complete),
                         itlet_pkg::IdW'(out_word_o.complete));
          if (out_word_o.accepted !== want.accepted)
            report_field("accepted", itlet_pkg::IdW'(want.accepted),
                         itlet_pkg::IdW'(out_word_o.accepted));
          if (out_word_o.evicted !== want.evicted)
            report_field("evicted", itlet_pkg::IdW'(want.evicted),
                         itlet_pkg::IdW'(out_word_o.evicted));
          if (out_word_o.evicted_id !== want.evicted_id)
            report_field("evicted_id", want.evicted_id, out_word_o.evicted_id);
        end
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    itlet_pkg::req_t w;
    int unsigned pick;
    logic [itlet_pkg::IdW-1:0] issued;
    bit timed_out;
    for (int i = 0; i < itlet_pkg::Entries; i++) begin
      tbl_valid[i]    = 1'b0;
      tbl_complete[i] = 1'b0;
      tbl_id[i]       = '0;
      tbl_rank[i]     = '0;
    end
    id_counter = itlet_pkg::IdReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        // directed: life of one entry, fill, eviction, absent ids, unused codes
        queued_requests.push_back('{req_type: itlet_pkg::ReqQuery,   entry_id: 32'd1});
        queued_requests.push_back('{req_type: itlet_pkg::ReqCreate,  entry_id: 32'hFFFF_FFFF});
        queued_requests.push_back('{req_type: itlet_pkg::ReqQuery,   entry_id: 32'd1});
        queued_requests.push_back('{req_type: itlet_pkg::ReqFetch,   entry_id: 32'd1});
        queued_requests.push_back('{req_type: itlet_pkg::ReqEndData, entry_id: 32'd1});
        queued_requests.push_back('{req_type: itlet_pkg::ReqEndData, entry_id: 32'd1});
        queued_requests.push_back('{req_type: itlet_pkg::ReqFetch,   entry_id: 32'd1});
        // eleven creates fill the table, the twelfth evicts the oldest
        repeat (12)
          queued_requests.push_back('{req_type: itlet_pkg::ReqCreate, entry_id: $urandom()});
        queued_requests.push_back('{req_type: itlet_pkg::ReqCancel,  entry_id: 32'd2});
        queued_requests.push_back('{req_type: itlet_pkg::ReqCancel,  entry_id: 32'd2});
        queued_requests.push_back('{req_type: itlet_pkg::ReqEndData, entry_id: 32'd0});
        queued_requests.push_back('{req_type: itlet_pkg::ReqFetch,   entry_id: 32'hFFFF_FFFF});
        for (int c = int'(itlet_pkg::ReqQuery) + 1; c < (1 << itlet_pkg::TypeW); c++) begin
          queued_requests.push_back('{req_type: itlet_pkg::TypeW'(c), entry_id: 32'd13});
        end
        // ids 1 to 13 are issued by the directed words
        issued = itlet_pkg::IdReset + 32'd13;
        while (queued_requests.size() != 0 || in_valid || predicted_results.size() != 0)
          @(negedge clk_i);

        // random: three phases, the middle one with no idling on either side
        for (int ph = 0; ph < 3; ph++) begin
          no_idle <= (ph == 1);
          repeat (420) begin
            pick = $urandom_range(0, 99);
            w.entry_id = $urandom();
            if (pick < 25)      w.req_type = itlet_pkg::ReqCreate;
            else if (pick < 45) w.req_type = itlet_pkg::ReqEndData;
            else if (pick < 65) w.req_type = itlet_pkg::ReqFetch;
            else if (pick < 75) w.req_type = itlet_pkg::ReqCancel;
            else if (pick < 90) w.req_type = itlet_pkg::ReqQuery;
            else w.req_type = itlet_pkg::TypeW'($urandom_range(0, (1 << itlet_pkg::TypeW) - 1));
            // mostly address one of the recently issued ids
            if (pick < 90 && $urandom_range(0, 9) != 0)
              w.entry_id = issued - itlet_pkg::IdW'(1 + $urandom_range(0, 15));
            if (w.req_type == itlet_pkg::ReqCreate) issued = issued + itlet_pkg::IdW'(1);
            queued_requests.push_back(w);
          end
          // sender holds off until every result of the phase is back
          while (queued_requests.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk_i);
        end
        repeat (TailCycles) @(posedge clk_i);
      end
      wait (idle_cycles >= StallLimit);
    join_any

    timed_out = (idle_cycles >= StallLimit);
    if (!timed_out && mismatches == 0 && predicted_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/itlet_pkg.sv
hw/rtl/itlet_lookup.sv
hw/rtl/itlet_table.sv
hw/rtl/id_tagged_lru_entry_table_core.sv
hw/rtl/itlet_checker.sv
tb/id_tagged_lru_entry_table_core_tb.sv
